/* hw/rtl/ssms_pkg.sv */
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared widths, defaults and the cell operation code for the stock span core.
// ----------------------------------------------------------------------------
package ssms_pkg;

	localparam int PRICE_W     = 32;
	localparam int SPAN_W      = 11;
	localparam int MAX_LEN_DEF = 1024;

	// Operation that the controller hands to every cell of the stack row.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_op_t;

	// Control bundle that travels from the controller to each cell.
	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

/* hw/rtl/ssms_in_if.sv */
// ----------------------------------------------------------------------------
// ssms_in_if
// Valid/ready channel that carries one price beat into the stock span core.
// ----------------------------------------------------------------------------
interface ssms_in_if;
	import ssms_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [PRICE_W-1:0] price;
	logic                      last_item;

	modport source (output valid, output price, output last_item, input ready);
	modport sink   (input valid, input price, input last_item, output ready);
endinterface

/* hw/rtl/ssms_out_if.sv */
// ----------------------------------------------------------------------------
// ssms_out_if
// Valid/ready channel that carries one span beat out of the stock span core.
// ----------------------------------------------------------------------------
interface ssms_out_if;
	import ssms_pkg::*;

	logic              valid;
	logic              ready;
	logic [SPAN_W-1:0] span_len;
	logic              overflow;

	modport source (output valid, output span_len, output overflow, input ready);
	modport sink   (input valid, input span_len, input overflow, output ready);
endinterface

/* hw/rtl/ssms_cell.sv */
// ----------------------------------------------------------------------------
// ssms_cell
// One entry of the shifting stack: holds a price and its position, and takes
// the entry above it on a push or the entry below it on a pop.
// ----------------------------------------------------------------------------
module ssms_cell import ssms_pkg::*; #(
	parameter int IDX_W = 10
) (
	input  logic                      clk,
	input  cell_ctrl_t                ctrl,
	input  logic signed [PRICE_W-1:0] up_value,
	input  logic [IDX_W-1:0]          up_index,
	input  logic signed [PRICE_W-1:0] dn_value,
	input  logic [IDX_W-1:0]          dn_index,
	output logic signed [PRICE_W-1:0] value,
	output logic [IDX_W-1:0]          index
);

	logic signed [PRICE_W-1:0] value_q;
	logic [IDX_W-1:0]          index_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_PUSH: begin
				value_q <= up_value;
				index_q <= up_index;
			end
			CELL_POP: begin
				value_q <= dn_value;
				index_q <= dn_index;
			end
			CELL_HOLD: begin
				value_q <= value_q;
				index_q <= index_q;
			end
			default: begin
				value_q <= value_q;
				index_q <= index_q;
			end
		endcase
	end

	assign value = value_q;
	assign index = index_q;

endmodule

/* hw/rtl/stock_span_monotonic_stack_core.sv */
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_core
// Computes the stock span of each price in a stream with a shifting stack.
// ----------------------------------------------------------------------------
// Usage: prices arrive as beats on the item channel (valid/ready) together
// with a last_item flag that closes a sequence. Each accepted beat produces
// exactly one beat on the result channel carrying span_len and overflow.
// The stack is a row of MAX_LEN cells with the top in cell 0. Every cycle
// the whole row either holds, shifts down by one (push) or shifts up by one
// (pop), so only the top cell is ever compared against the new price.
// An item that pops k entries stays in the core for those pops and a final
// push cycle; its result is registered at the end of that last cycle. The next
// item is taken in that same cycle, so the core works on one item at a time.
// Every item is pushed once and popped at most once. An item past MAX_LEN
// of its sequence pops nothing and is not pushed.
// Reset clears the stack depth, the position counter and the result valid;
// the cell contents are left as they are and are never read before written.
// When the receiver stalls, the finished result waits in the output register
// while the next item is still accepted and popped; only its push waits for
// the output register to free up.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack_core import ssms_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssms_in_if.sink     item,
	ssms_out_if.source  result
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int EXT_W = SPAN_W + POS_W;

	// Control state.
	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] count_q;
	logic             res_valid_q;

	// Payload of the item in work and of the waiting result.
	logic signed [PRICE_W-1:0] key_q;
	logic                      last_q;
	logic [SPAN_W-1:0]         span_q;
	logic                      overflow_q;

	// Stack row.
	logic signed [PRICE_W-1:0] cell_value [MAX_LEN];
	logic [IDX_W-1:0]          cell_index [MAX_LEN];
	cell_ctrl_t                cell_ctrl;

	logic             out_free;
	logic             ovf_item;
	logic             pop_now;
	logic             finish;
	logic             accept;
	logic [POS_W-1:0] span_pos;
	logic [EXT_W-1:0] span_ext;

	// The output register can take a new result when empty or being drained.
	assign out_free = !res_valid_q || result.ready;

	// The item lies beyond MAX_LEN entries of its sequence.
	assign ovf_item = (pos_q >= POS_W'(MAX_LEN));

	// Pop while the top entry is no greater than the price in work. Entries
	// below the top hold larger prices, so one compare per cycle suffices.
	assign pop_now = busy_q && !ovf_item && (count_q != '0) && (cell_value[0] <= key_q);

	// The item completes once no pop remains and the result has a place.
	assign finish = busy_q && !pop_now && out_free;

	assign item.ready = !busy_q || finish;
	assign accept     = item.valid && item.ready;

	// With an empty stack the span reaches back to the start of the sequence.
	assign span_pos = (count_q == '0) ? (pos_q + POS_W'(1))
	                                  : (pos_q - POS_W'(cell_index[0]));
	assign span_ext = EXT_W'(span_pos);

	always_comb begin
		priority if (pop_now) begin
			cell_ctrl.op = CELL_POP;
		end else if (finish && !ovf_item) begin
			cell_ctrl.op = CELL_PUSH;
		end else begin
			cell_ctrl.op = CELL_HOLD;
		end
	end

	// Row of cells: cell 0 takes the new entry on a push, the bottom cell
	// takes nothing meaningful on a pop because it lies beyond the depth.
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic signed [PRICE_W-1:0] up_value;
		logic [IDX_W-1:0]          up_index;
		logic signed [PRICE_W-1:0] dn_value;
		logic [IDX_W-1:0]          dn_index;

		if (i == 0) begin : g_top
			assign up_value = key_q;
			assign up_index = pos_q[IDX_W-1:0];
		end else begin : g_mid
			assign up_value = cell_value[i-1];
			assign up_index = cell_index[i-1];
		end

		if (i == MAX_LEN - 1) begin : g_bottom
			assign dn_value = '0;
			assign dn_index = '0;
		end else begin : g_inner
			assign dn_value = cell_value[i+1];
			assign dn_index = cell_index[i+1];
		end

		ssms_cell #(
			.IDX_W (IDX_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.up_value (up_value),
			.up_index (up_index),
			.dn_value (dn_value),
			.dn_index (dn_index),
			.value    (cell_value[i]),
			.index    (cell_index[i])
		);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end

			if (pop_now) begin
				count_q <= count_q - POS_W'(1);
			end else if (finish) begin
				if (last_q) begin
					count_q <= '0;
					pos_q   <= '0;
				end else if (!ovf_item) begin
					count_q <= count_q + POS_W'(1);
					pos_q   <= pos_q + POS_W'(1);
				end
			end

			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= item.price;
			last_q <= item.last_item;
		end
		if (finish) begin
			span_q     <= ovf_item ? '0 : span_ext[SPAN_W-1:0];
			overflow_q <= ovf_item;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.span_len = span_q;
	assign result.overflow = overflow_q;

	// The stack never holds more entries than items seen in the sequence.
	a_depth_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pos_q)
		else $error("stack depth exceeds sequence position");

	// A pop only happens on a non-empty stack.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_ctrl.op == CELL_POP) |-> (count_q != '0))
		else $error("pop on an empty stack");

	// Completing a last item returns the sequence state to its start.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && last_q) |=> (pos_q == '0) && (count_q == '0))
		else $error("sequence state not cleared after last item");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the stock span core: a scoreboard tracks its own
// monotonic stack per sequence, while randomly paced sender and receiver tasks
// push price beats through directed, long-sequence and random phases.
// ----------------------------------------------------------------------------
module tb;
	import ssms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [PRICE_W-1:0] PRICE_MIN = 32'sh8000_0000;
	localparam logic signed [PRICE_W-1:0] PRICE_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 100;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 20;

	// One expected beat on the result channel.
	typedef struct packed {
		logic [SPAN_W-1:0] span_len;
		logic              overflow;
	} span_beat_t;

	// Kinds of price stream used by the random phase.
	typedef enum int {
		PM_FULL,
		PM_NARROW,
		PM_WALK
	} price_mode_t;

	// The scoreboard keeps its own copy of the stack and the position in the
	// sequence. Each accepted price beat is turned into the span it must
	// produce, and result beats are matched against those in order.
	class span_scoreboard;
		logic signed [PRICE_W-1:0] stk_price [MAX_LEN_DEF];
		int unsigned               stk_pos   [MAX_LEN_DEF];
		int unsigned               depth;
		int unsigned               seq_pos;
		span_beat_t                span_q [$];
		int unsigned               errors;

		function new();
			depth   = 0;
			seq_pos = 0;
			errors  = 0;
		endfunction

		function void note_item(logic signed [PRICE_W-1:0] price, logic last_item);
			span_beat_t  beat;
			int unsigned span;
			if (seq_pos >= MAX_LEN_DEF) begin
				// Past the end of the sequence window: flagged, state untouched.
				beat.span_len = '0;
				beat.overflow = 1'b1;
			end else begin
				// Equal earlier prices are popped too, so they join the span.
				while (depth > 0 && stk_price[depth-1] <= price)
					depth--;
				span = (depth == 0) ? seq_pos + 1 : seq_pos - stk_pos[depth-1];
				stk_price[depth] = price;
				stk_pos[depth]   = seq_pos;
				depth++;
				seq_pos++;
				beat.span_len = span[SPAN_W-1:0];
				beat.overflow = 1'b0;
			end
			if (last_item) begin
				depth   = 0;
				seq_pos = 0;
			end
			span_q.push_back(beat);
		endfunction

		function void check_span(logic [SPAN_W-1:0] span_len, logic overflow);
			span_beat_t want;
			if (span_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing pending: span_len=%0d overflow=%0b",
					$time, span_len, overflow);
				return;
			end
			want = span_q.pop_front();
			if (span_len !== want.span_len) begin
				errors++;
				$display("%0t: span_len mismatch: expected %0d, actual %0d",
					$time, want.span_len, span_len);
			end
			if (overflow !== want.overflow) begin
				errors++;
				$display("%0t: overflow mismatch: expected %0b, actual %0b",
					$time, want.overflow, overflow);
			end
		endfunction

		function int unsigned pending();
			return span_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ssms_in_if  item_ch ();
	ssms_out_if result_ch ();

	stock_span_monotonic_stack_core #(
		.MAX_LEN(MAX_LEN_DEF)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	span_scoreboard sb = new();

	// Pacing knobs shared by the sender and the receiver. When an idle flag is
	// clear that side runs back to back. A burst count forces the sender to
	// stream without gaps, and the hold request makes the receiver stall for
	// a long stretch so that the core backs up into its input.
	bit tx_idle;
	bit rx_idle;
	int burst_left;
	bit hold_req;

	// Directed opening: extremes of the price range, equal prices, a classic
	// textbook series and single-item sequences.
	logic signed [PRICE_W-1:0] dir_price [17] = '{
		PRICE_MAX,
		PRICE_MIN, PRICE_MAX, PRICE_MAX, 32'sd0, -32'sd1, 32'sd0, 32'sd1, PRICE_MIN,
		32'sd100, 32'sd80, 32'sd60, 32'sd70, 32'sd60, 32'sd75, 32'sd85,
		PRICE_MIN
	};
	bit dir_last [17] = '{
		1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b1
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one price beat and returns once the core has taken it. Inputs
	// move only on the falling edge; acceptance is judged at the rising edge.
	// The valid line is lowered only when a gap is drawn, so back-to-back
	// beats never see valid dropped and raised in the same time step.
	task automatic send_price(input logic signed [PRICE_W-1:0] price, input logic last_item);
		int gap;
		gap = (tx_idle && burst_left == 0) ? $urandom_range(0, 10) : 0;
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.price     <= price;
		item_ch.last_item <= last_item;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_item(price, last_item);
	endtask

	// Lets the core drain: the sender stops until every span is back.
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Receiver: draws a random stall before each result beat while its idle flag
	// is set, and honors a long hold-off request counted here in its own cycles.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = rx_idle ? $urandom_range(0, 10) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap      = LONG_HOLD;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			sb.check_span(result_ch.span_len, result_ch.overflow);
		end
	end

	// Main stimulus.
	initial begin
		int                        rand_count;
		int                        seq_len;
		int                        walk;
		bit                        pause_done;
		price_mode_t               mode;
		logic signed [PRICE_W-1:0] price;

		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.price       = '0;
		item_ch.last_item   = 1'b0;
		result_ch.ready     = 1'b0;
		tx_idle             = 1'b1;
		rx_idle             = 1'b1;
		burst_left          = 0;
		hold_req            = 1'b0;
		rand_count          = 0;
		pause_done          = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_price[i])
			send_price(dir_price[i], dir_last[i]);
		wait_drained();

		// One strictly falling sequence fills the stack to MAX_LEN-1 entries.
		// A maximum price then pops all of them for the largest span, and the
		// items after it lie past the window; the last of them closes the
		// sequence, which must clear the overflow state. At its start the
		// receiver holds off for a long stretch while the sender streams.
		tx_idle    = ($urandom_range(0, 1) != 0);
		rx_idle    = ($urandom_range(0, 1) != 0);
		hold_req   = 1'b1;
		burst_left = 80;
		for (int i = 0; i < MAX_LEN_DEF - 1; i++)
			send_price(32'sd2000000 - 32'sd3 * i, 1'b0);
		send_price(PRICE_MAX, 1'b0);
		send_price($urandom(), 1'b0);
		send_price(PRICE_MIN, 1'b0);
		send_price($urandom(), 1'b1);
		wait_drained();

		// Random sequences of mixed length, price style and pacing. Narrow
		// prices give many equal values, walks give long spans, and full-range
		// prices exercise every bit.
		while (rand_count < RANDOM_ITEMS) begin
			seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 40);
			mode    = price_mode_t'($urandom_range(0, 2));
			walk    = $urandom();
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if (!pause_done && rand_count >= 50) begin
				pause_done = 1'b1;
				wait_drained();
			end
			for (int i = 0; i < seq_len; i++) begin
				case (mode)
					PM_FULL:   price = $urandom();
					PM_NARROW: price = $urandom_range(0, 15) - 8;
					default: begin
						walk  = walk + $urandom_range(0, 6) - 2;
						price = walk;
					end
				endcase
				if ($urandom_range(0, 15) == 0)
					price = $urandom_range(0, 1) ? PRICE_MAX : PRICE_MIN;
				send_price(price, i == seq_len - 1);
				rand_count++;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("stock_span_monotonic_stack_core regression: pass");
		else
			$display("stock_span_monotonic_stack_core regression: fail");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#5000000;
		$display("stock_span_monotonic_stack_core regression: fail");
		$finish;
	end

endmodule
